@@ src/cartridge_bank_mapper_irq_unit_macros.svh @@
// Assertion macros for the cartridge bank mapper IRQ unit.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, held off during reset.
`define CBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbm assertion failed");
// Next-cycle implication, checked on clk, held off during reset.
`define CBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbm assertion failed");
`else
`define CBM_ASSERT_NOW(label, ante, cons)
`define CBM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/cbm_pkg.sv @@
// Shared types and constants of the cartridge bank mapper IRQ unit.
`timescale 1ns / 1ps

package cbm_pkg;

  // Request codes of an input beat.
  typedef enum logic [2:0] {
    REQ_WRITE     = 3'd0,
    REQ_LOW_READ  = 3'd1,
    REQ_TICK      = 3'd2,
    REQ_CPU_XLATE = 3'd3,
    REQ_PPU_XLATE = 3'd4
  } req_t;

  // PRG modes, taken from mode bits 1:0.
  localparam logic [1:0] PRG_MODE_PAIRS = 2'd1;
  localparam logic [1:0] PRG_MODE_FIXED = 2'd2;

  // CHR page sizes, taken from mode bits 4:3.
  localparam logic [1:0] CHR_MODE_8K = 2'd0;
  localparam logic [1:0] CHR_MODE_4K = 2'd1;
  localparam logic [1:0] CHR_MODE_2K = 2'd2;
  localparam logic [1:0] CHR_MODE_1K = 2'd3;

  // Exact addresses of the low region.
  localparam logic [15:0] ADDR_TOGGLE = 16'h5000;
  localparam logic [15:0] ADDR_MUL_LO = 16'h5800;
  localparam logic [15:0] ADDR_MUL_HI = 16'h5801;
  localparam logic [15:0] ADDR_SPARE  = 16'h5803;

  // Decoded write addresses, compared after masking.
  localparam logic [15:0] DEC_MASK      = 16'hF007;
  localparam logic [15:0] DEC_PRG_BASE  = 16'h8000;
  localparam logic [15:0] DEC_CHR_BASE  = 16'h9000;
  localparam logic [15:0] DEC_IRQ_OFF   = 16'hC002;
  localparam logic [15:0] DEC_IRQ_ON_A  = 16'hC003;
  localparam logic [15:0] DEC_IRQ_ON_B  = 16'hC004;
  localparam logic [15:0] DEC_IRQ_LATCH = 16'hC005;
  localparam logic [15:0] DEC_MODE      = 16'hE000;

  // Toggle byte, never written.
  localparam logic [7:0] TOGGLE_BYTE = 8'hFF;

  // Reset values.
  localparam logic [8:0] ROM_BANKS_RESET = 9'd32;
  localparam logic [8:0] PRG_LAST_RESET  = 9'd31;

  // Bank select and window arrays.
  typedef logic [3:0][7:0]  prg_sel_t;
  typedef logic [7:0][7:0]  chr_sel_t;
  typedef logic [3:0][8:0]  prg_win_t;
  typedef logic [7:0][10:0] chr_win_t;

  // One result beat.
  typedef struct packed {
    logic [7:0]  read_data;
    logic [10:0] bank_number;
    logic        irq_assert;
  } result_t;

endpackage

@@ src/cbm_window_calc.sv @@
// Bank window computation for the PRG and CHR groups from the current mode.
`timescale 1ns / 1ps

module cbm_window_calc import cbm_pkg::*; (
  input  logic [7:0] mode,
  input  logic [8:0] rom_banks,
  input  prg_sel_t   prg_sel,
  input  chr_sel_t   chr_sel,
  output prg_win_t   prg_win,
  output logic       prg_apply,
  output chr_win_t   chr_win
);

  // PRG windows: paired 8K banks or three banks plus a fixed last bank; other modes are not applied.
  always_comb begin
    prg_win   = '0;
    prg_apply = 1'b0;
    case (mode[1:0])
      PRG_MODE_PAIRS: begin
        prg_apply  = 1'b1;
        prg_win[0] = {prg_sel[0], 1'b0};
        prg_win[1] = {prg_sel[0], 1'b1};
        prg_win[2] = {prg_sel[2], 1'b0};
        prg_win[3] = {prg_sel[2], 1'b1};
      end
      PRG_MODE_FIXED: begin
        prg_apply  = 1'b1;
        prg_win[0] = {1'b0, prg_sel[0]};
        prg_win[1] = {1'b0, prg_sel[1]};
        prg_win[2] = {1'b0, prg_sel[2]};
        prg_win[3] = rom_banks - 9'd1;
      end
      default: begin
        prg_apply = 1'b0;
      end
    endcase
  end

  // CHR windows: each 1K slot takes its page select and its offset in the page.
  always_comb begin
    logic [2:0] slot;
    chr_win = '0;
    for (int i = 0; i < 8; i++) begin
      slot = 3'(i);
      case (mode[4:3])
        CHR_MODE_8K: chr_win[i] = {chr_sel[0], slot};
        CHR_MODE_4K: chr_win[i] = {1'b0, chr_sel[{slot[2], 2'b00}], slot[1:0]};
        CHR_MODE_2K: chr_win[i] = {2'b00, chr_sel[{slot[2:1], 1'b0}], slot[0]};
        CHR_MODE_1K: chr_win[i] = {3'b000, chr_sel[slot]};
        default:     chr_win[i] = '0;
      endcase
    end
  end

endmodule

@@ src/cbm_out_buffer.sv @@
// Output register with a skid stage, so a new beat is taken while a result waits.
`timescale 1ns / 1ps

module cbm_out_buffer import cbm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    head_free;

  assign head_free = !out_valid || !out_stall;
  assign full      = skid_valid;

  // Valid flags: the skid drains into the head first; the source waits while it is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      out_valid  <= skid_valid || load;
      skid_valid <= 1'b0;
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (load) begin
        out_data <= load_data;
      end
    end else if (load) begin
      skid_data <= load_data;
    end
  end

endmodule

@@ src/cartridge_bank_mapper_irq_unit.sv @@
// Top level of the cartridge bank mapper with multiplier and scanline IRQ counter.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   cfg     | in        | cfg_we                | cfg_wdata (rom_banks_8k)
//   in      | in        | in_valid / in_stall   | req_type, address, write_data
//   out     | out       | out_valid / out_stall | read_data, bank_number, irq_assert
//
// Every accepted beat yields one registered result beat; one beat per cycle unless stalled.
// The mapper state is updated at the edge that accepts the beat, so the next beat sees it.
// A two-entry output stage (register plus skid) takes one more beat while the output
// is stalled; in_stall rises only while the skid entry is occupied, and stays high until
// the skid drains into the output register once the stall ends.
// Synchronous active-high reset restores all bank, mode and IRQ state.
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_irq_unit_macros.svh"

module cartridge_bank_mapper_irq_unit import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [10:0] bank_number,
  output logic        irq_assert
);

  // Mapper state.
  logic [8:0] rom_banks;
  prg_sel_t   prg_select;
  chr_sel_t   chr_select;
  logic [7:0] mode_reg;
  prg_win_t   prg_window;
  chr_win_t   chr_window;
  logic [7:0] mul_op0;
  logic [7:0] mul_op1;
  logic [7:0] spare_byte;
  logic [7:0] irq_reload;
  logic [7:0] irq_count;
  logic       irq_armed;

  // Next values and decode.
  prg_sel_t    prg_select_next;
  chr_sel_t    chr_select_next;
  prg_win_t    prg_calc;
  chr_win_t    chr_calc;
  logic        prg_apply;
  logic [7:0]  mode_reg_next;
  logic [7:0]  mul_op0_next;
  logic [7:0]  mul_op1_next;
  logic [7:0]  spare_byte_next;
  logic [7:0]  irq_reload_next;
  logic [7:0]  irq_count_next;
  logic        irq_armed_next;
  logic        prg_hit;
  logic        chr_hit;
  logic [15:0] dec_addr;
  logic [15:0] product;
  logic [7:0]  count_dec;
  logic        in_accept;
  logic        buf_full;
  result_t     result;
  result_t     out_data;

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;
  assign dec_addr  = address & DEC_MASK;
  assign product   = 16'(mul_op0) * 16'(mul_op1);
  assign count_dec = (irq_count != 8'd0) ? irq_count - 8'd1 : 8'd0;

  // Request decode: next state and result for the beat at the input.
  always_comb begin
    logic exact;
    prg_select_next = prg_select;
    chr_select_next = chr_select;
    mode_reg_next   = mode_reg;
    mul_op0_next    = mul_op0;
    mul_op1_next    = mul_op1;
    spare_byte_next = spare_byte;
    irq_reload_next = irq_reload;
    irq_count_next  = irq_count;
    irq_armed_next  = irq_armed;
    prg_hit         = 1'b0;
    chr_hit         = 1'b0;
    result          = '0;
    exact = (address == ADDR_MUL_LO) || (address == ADDR_MUL_HI) || (address == ADDR_SPARE);
    unique case (req_type)
      REQ_WRITE: begin
        if (address == ADDR_MUL_LO) begin
          mul_op0_next = write_data;
        end else if (address == ADDR_MUL_HI) begin
          mul_op1_next = write_data;
        end else if (address == ADDR_SPARE) begin
          spare_byte_next = write_data;
        end
        if (!exact) begin
          if (dec_addr[15:2] == DEC_PRG_BASE[15:2]) begin
            prg_hit = 1'b1;
            prg_select_next[address[1:0]] = write_data;
          end else if (dec_addr[15:3] == DEC_CHR_BASE[15:3]) begin
            chr_hit = 1'b1;
            chr_select_next[address[2:0]] = write_data;
          end else if (dec_addr == DEC_IRQ_OFF) begin
            irq_armed_next = 1'b0;
          end else if (dec_addr == DEC_IRQ_ON_A || dec_addr == DEC_IRQ_ON_B) begin
            if (!irq_armed) begin
              irq_armed_next = 1'b1;
              irq_count_next = irq_reload;
            end
          end else if (dec_addr == DEC_IRQ_LATCH) begin
            irq_count_next  = write_data;
            irq_reload_next = write_data;
          end else if (dec_addr == DEC_MODE) begin
            mode_reg_next = write_data;
          end
        end
      end
      REQ_LOW_READ: begin
        if (address == ADDR_TOGGLE) begin
          result.read_data = TOGGLE_BYTE;
        end else if (address == ADDR_MUL_LO) begin
          result.read_data = product[7:0];
        end else if (address == ADDR_MUL_HI) begin
          result.read_data = product[15:8];
        end else if (address == ADDR_SPARE) begin
          result.read_data = spare_byte;
        end
      end
      REQ_TICK: begin
        irq_count_next = count_dec;
        if (count_dec == 8'd0) begin
          result.irq_assert = irq_armed;
          irq_armed_next    = 1'b0;
        end
      end
      REQ_CPU_XLATE: begin
        if (address[15]) begin
          result.bank_number = {2'b00, prg_window[address[14:13]]};
        end
      end
      REQ_PPU_XLATE: begin
        if (address[15:13] == 3'd0) begin
          result.bank_number = chr_window[address[12:10]];
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // Window computation for the group that a bank write touches.
  cbm_window_calc u_window_calc (
    .mode      (mode_reg),
    .rom_banks (rom_banks),
    .prg_sel   (prg_select_next),
    .chr_sel   (chr_select_next),
    .prg_win   (prg_calc),
    .prg_apply (prg_apply),
    .chr_win   (chr_calc)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_banks <= ROM_BANKS_RESET;
    end else if (cfg_we) begin
      rom_banks <= cfg_wdata;
    end
  end

  // State update on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_select <= '0;
      for (int i = 0; i < 8; i++) begin
        chr_select[i] <= 8'(i);
        chr_window[i] <= 11'(i);
      end
      mode_reg      <= '0;
      prg_window[0] <= 9'd0;
      prg_window[1] <= 9'd1;
      prg_window[2] <= 9'd2;
      prg_window[3] <= PRG_LAST_RESET;
      mul_op0       <= '0;
      mul_op1       <= '0;
      spare_byte    <= '0;
      irq_reload    <= '0;
      irq_count     <= '0;
      irq_armed     <= 1'b0;
    end else if (in_accept) begin
      prg_select <= prg_select_next;
      chr_select <= chr_select_next;
      mode_reg   <= mode_reg_next;
      mul_op0    <= mul_op0_next;
      mul_op1    <= mul_op1_next;
      spare_byte <= spare_byte_next;
      irq_reload <= irq_reload_next;
      irq_count  <= irq_count_next;
      irq_armed  <= irq_armed_next;
      if (prg_hit && prg_apply) begin
        prg_window <= prg_calc;
      end
      if (chr_hit) begin
        chr_window <= chr_calc;
      end
    end
  end

  // Result register and skid stage.
  cbm_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .load_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign read_data   = out_data.read_data;
  assign bank_number = out_data.bank_number;
  assign irq_assert  = out_data.irq_assert;

  // Checks on the output stage and the IRQ counter.
  `CBM_ASSERT_NOW(a_skid_needs_head, buf_full, out_valid)
  `CBM_ASSERT_NEXT(a_stall_fills_skid, in_accept && out_valid && out_stall, buf_full)
  `CBM_ASSERT_NEXT(a_irq_one_shot, in_accept && req_type == REQ_TICK && irq_count <= 8'd1, !irq_armed)
  `CBM_ASSERT_NOW(a_one_field_live, out_valid, read_data == 8'd0 || bank_number == 11'd0)

endmodule

@@ tb/sv/cartridge_bank_mapper_irq_unit_test.sv @@
// Self-checking testbench for the cartridge bank mapper IRQ unit.
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq_unit_test import cbm_pkg::*;;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int HANG_LIMIT = 500;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  req_type = '0;
  logic [15:0] address = '0;
  logic [7:0]  write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic [10:0] bank_number;
  logic        irq_assert;

  // Mapper state as the predictor sees it.
  logic [8:0]  rom_banks;
  prg_sel_t    prg_bank;
  chr_sel_t    chr_bank;
  logic [7:0]  mode_bits;
  prg_win_t    prg_map;
  chr_win_t    chr_map;
  logic [7:0]  mul_lhs;
  logic [7:0]  mul_rhs;
  logic [7:0]  spare_reg;
  logic [7:0]  reload_value;
  logic [7:0]  count_value;
  logic        armed_flag;

  result_t     pending_responses[$];
  int          failures = 0;
  int          quiet_cycles = 0;
  int          max_in_wait = 6;
  int          max_out_wait = 6;
  int          out_hold = 0;

  cartridge_bank_mapper_irq_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .address     (address),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .bank_number (bank_number),
    .irq_assert  (irq_assert)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bring the predicted state to its post-reset values.
  task automatic reset_mapper_state();
    int i;
    rom_banks = ROM_BANKS_RESET;
    prg_bank = '0;
    for (i = 0; i < 8; i++) begin
      chr_bank[i] = 8'(i);
      chr_map[i] = 11'(i);
    end
    mode_bits = '0;
    prg_map[0] = 9'd0;
    prg_map[1] = 9'd1;
    prg_map[2] = 9'd2;
    prg_map[3] = PRG_LAST_RESET;
    mul_lhs = '0;
    mul_rhs = '0;
    spare_reg = '0;
    reload_value = '0;
    count_value = '0;
    armed_flag = 1'b0;
  endtask

  // Advance the predicted state by one request and return the response it causes.
  function automatic result_t predict_response(logic [2:0] req, logic [15:0] addr,
                                               logic [7:0] data);
    result_t     resp;
    logic [15:0] dec;
    logic [15:0] product;
    int          i;
    resp = '0;
    dec = addr & DEC_MASK;
    product = 16'(mul_lhs) * 16'(mul_rhs);
    case (req)
      REQ_WRITE: begin
        if (addr == ADDR_MUL_LO) mul_lhs = data;
        else if (addr == ADDR_MUL_HI) mul_rhs = data;
        else if (addr == ADDR_SPARE) spare_reg = data;
        else if (dec >= DEC_PRG_BASE && dec <= DEC_PRG_BASE + 16'd3) begin
          // A PRG select write re-applies the PRG mode.
          prg_bank[dec[1:0]] = data;
          case (mode_bits[1:0])
            PRG_MODE_PAIRS: begin
              prg_map[0] = {prg_bank[0], 1'b0};
              prg_map[1] = {prg_bank[0], 1'b1};
              prg_map[2] = {prg_bank[2], 1'b0};
              prg_map[3] = {prg_bank[2], 1'b1};
            end
            PRG_MODE_FIXED: begin
              prg_map[0] = {1'b0, prg_bank[0]};
              prg_map[1] = {1'b0, prg_bank[1]};
              prg_map[2] = {1'b0, prg_bank[2]};
              prg_map[3] = rom_banks - 9'd1;
            end
            default: ;
          endcase
        end else if (dec >= DEC_CHR_BASE && dec <= DEC_CHR_BASE + 16'd7) begin
          // A CHR select write re-applies the CHR page size to all windows.
          chr_bank[dec[2:0]] = data;
          for (i = 0; i < 8; i++) begin
            case (mode_bits[4:3])
              CHR_MODE_8K: chr_map[i] = (11'(chr_bank[0]) << 3) + 11'(i);
              CHR_MODE_4K: chr_map[i] = (11'(chr_bank[i & 4]) << 2) + 11'(i & 3);
              CHR_MODE_2K: chr_map[i] = (11'(chr_bank[i & 6]) << 1) + 11'(i & 1);
              default:     chr_map[i] = 11'(chr_bank[i]);
            endcase
          end
        end else if (dec == DEC_IRQ_OFF) begin
          armed_flag = 1'b0;
        end else if (dec == DEC_IRQ_ON_A || dec == DEC_IRQ_ON_B) begin
          if (!armed_flag) begin
            armed_flag = 1'b1;
            count_value = reload_value;
          end
        end else if (dec == DEC_IRQ_LATCH) begin
          count_value = data;
          reload_value = data;
        end else if (dec == DEC_MODE) begin
          mode_bits = data;
        end
      end
      REQ_LOW_READ: begin
        case (addr)
          ADDR_TOGGLE: resp.read_data = TOGGLE_BYTE;
          ADDR_MUL_LO: resp.read_data = product[7:0];
          ADDR_MUL_HI: resp.read_data = product[15:8];
          ADDR_SPARE:  resp.read_data = spare_reg;
          default:     resp.read_data = '0;
        endcase
      end
      REQ_TICK: begin
        // The interrupt fires once, when the count lands on zero while armed.
        if (count_value != 8'd0) count_value = count_value - 8'd1;
        if (count_value == 8'd0) begin
          resp.irq_assert = armed_flag;
          armed_flag = 1'b0;
        end
      end
      REQ_CPU_XLATE: begin
        if (addr[15]) resp.bank_number = 11'(prg_map[addr[14:13]]);
      end
      REQ_PPU_XLATE: begin
        if (addr[15:13] == 3'b000) resp.bank_number = chr_map[addr[12:10]];
      end
      default: ;
    endcase
    return resp;
  endfunction

  // Present one request beat after a random gap and hold it until accepted.
  task automatic send_request(logic [2:0] req, logic [15:0] addr, logic [7:0] data);
    int gap;
    gap = $urandom_range(0, max_in_wait);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type <= req;
    address <= addr;
    write_data <= data;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_responses.push_back(predict_response(req, addr, data));
  endtask

  // Stop sending and wait until every predicted response has been checked.
  task automatic drain_responses();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write the ROM size register; only called while the block is idle.
  task automatic set_rom_banks(logic [8:0] banks);
    cfg_wdata <= banks;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    rom_banks = banks;
  endtask

  // Response checker, output stall generator and hang watchdog.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_responses.size() == 0) begin
          $error("response beat with no request outstanding");
          failures++;
        end else begin
          want = pending_responses.pop_front();
          if (read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, read_data);
            failures++;
          end
          if (bank_number !== want.bank_number) begin
            $error("bank_number: expected %0h, got %0h", want.bank_number, bank_number);
            failures++;
          end
          if (irq_assert !== want.irq_assert) begin
            $error("irq_assert: expected %0b, got %0b", want.irq_assert, irq_assert);
            failures++;
          end
        end
        out_hold = $urandom_range(0, max_out_wait);
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Multiplier, spare byte, toggle byte and an unmapped low address.
  task automatic test_low_region();
    send_request(REQ_WRITE, ADDR_MUL_LO, 8'hFF);
    send_request(REQ_WRITE, ADDR_MUL_HI, 8'hFF);
    send_request(REQ_WRITE, ADDR_SPARE, 8'hA5);
    send_request(REQ_LOW_READ, ADDR_TOGGLE, 8'h00);
    send_request(REQ_LOW_READ, ADDR_MUL_LO, 8'h00);
    send_request(REQ_LOW_READ, ADDR_MUL_HI, 8'h00);
    send_request(REQ_LOW_READ, ADDR_SPARE, 8'h00);
    send_request(REQ_LOW_READ, 16'h5802, 8'hFF);
  endtask

  // PRG pairs with 1K CHR, then fixed PRG with 8K CHR, and out-of-range queries.
  task automatic test_bank_windows();
    send_request(REQ_WRITE, DEC_MODE, 8'h19);
    send_request(REQ_WRITE, DEC_PRG_BASE, 8'hFF);
    send_request(REQ_CPU_XLATE, 16'hE000, 8'h00);
    send_request(REQ_WRITE, DEC_CHR_BASE + 16'd7, 8'h80);
    send_request(REQ_PPU_XLATE, 16'h1FFF, 8'h00);
    send_request(REQ_WRITE, DEC_MODE, 8'h02);
    send_request(REQ_WRITE, DEC_CHR_BASE, 8'hFF);
    send_request(REQ_PPU_XLATE, 16'h1C00, 8'h00);
    send_request(REQ_CPU_XLATE, 16'hFFFF, 8'h00);
    send_request(REQ_CPU_XLATE, 16'h7FFF, 8'h00);
    send_request(REQ_PPU_XLATE, 16'h2000, 8'h00);
  endtask

  // Latch, arm, count down to the one-shot interrupt, then re-arm, disarm and an unknown request.
  task automatic test_irq_counter();
    send_request(REQ_WRITE, DEC_IRQ_LATCH, 8'h02);
    send_request(REQ_WRITE, DEC_IRQ_ON_A, 8'h00);
    send_request(REQ_TICK, 16'h0000, 8'h00);
    send_request(REQ_TICK, 16'h0000, 8'h00);
    send_request(REQ_TICK, 16'h0000, 8'h00);
    send_request(REQ_WRITE, DEC_IRQ_ON_B, 8'h00);
    send_request(REQ_WRITE, DEC_IRQ_OFF, 8'h00);
    send_request(3'd7, 16'hFFFF, 8'hFF);
  endtask

  // The fixed last PRG window follows the ROM size register at both extremes.
  task automatic test_rom_size_register();
    logic [8:0] sizes [2];
    int k;
    sizes[0] = 9'd2;
    sizes[1] = 9'd256;
    for (k = 0; k < 2; k++) begin
      drain_responses();
      set_rom_banks(sizes[k]);
      send_request(REQ_WRITE, DEC_MODE, 8'h02);
      send_request(REQ_WRITE, DEC_PRG_BASE + 16'd2, 8'($urandom));
      send_request(REQ_CPU_XLATE, 16'hE000, 8'h00);
    end
  endtask

  // Random mix of requests that favors meaningful register addresses.
  task automatic run_random_requests(int count);
    int          n;
    int          pick;
    int          sub;
    logic [2:0]  req;
    logic [15:0] addr;
    logic [7:0]  data;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      sub = $urandom_range(0, 9);
      addr = 16'($urandom);
      data = 8'($urandom);
      if (pick < 30) begin
        req = REQ_WRITE;
        case (sub)
          0: addr = ADDR_MUL_LO;
          1: addr = ADDR_MUL_HI;
          2: addr = ADDR_SPARE;
          3: addr = {4'h8, addr[11:0]};
          4: addr = {4'h9, addr[11:0]};
          5, 6: begin
            // IRQ control; keep the latch value small so interrupts come often.
            addr = {4'hC, addr[11:3], 3'($urandom_range(2, 5))};
            if (addr[2:0] == DEC_IRQ_LATCH[2:0]) data = 8'($urandom_range(0, 6));
          end
          7: addr = {4'hE, addr[11:3], 3'b000};
          8: addr = {4'hB, addr[11:0]};
          default: ;
        endcase
      end else if (pick < 40) begin
        req = REQ_LOW_READ;
        case (sub)
          0, 1: addr = ADDR_TOGGLE;
          2, 3: addr = ADDR_MUL_LO;
          4, 5: addr = ADDR_MUL_HI;
          6, 7: addr = ADDR_SPARE;
          default: ;
        endcase
      end else if (pick < 62) begin
        req = REQ_TICK;
      end else if (pick < 77) begin
        req = REQ_CPU_XLATE;
      end else if (pick < 95) begin
        req = REQ_PPU_XLATE;
        if (sub < 8) addr[15:13] = 3'b000;
      end else begin
        req = 3'($urandom_range(5, 7));
      end
      send_request(req, addr, data);
    end
  endtask

  // Random phases, each under a chosen ROM size and idling profile.
  task automatic test_random_traffic();
    logic [8:0] sizes [6];
    int k;
    sizes[0] = ROM_BANKS_RESET;
    sizes[1] = 9'd2;
    sizes[2] = 9'd256;
    sizes[3] = 9'($urandom_range(2, 256));
    sizes[4] = 9'($urandom_range(2, 256));
    sizes[5] = 9'd255;
    for (k = 0; k < 6; k++) begin
      drain_responses();
      set_rom_banks(sizes[k]);
      max_in_wait = (k == 1) ? 0 : 6;
      max_out_wait = (k == 1 || k == 4) ? 0 : 6;
      run_random_requests(320);
    end
    max_in_wait = 6;
    max_out_wait = 6;
  endtask

  initial begin
    reset_mapper_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_low_region();
    test_bank_windows();
    test_irq_counter();
    test_rom_size_register();
    test_random_traffic();
    drain_responses();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ cartridge_bank_mapper_irq_unit.f @@
+incdir+src
src/cbm_pkg.sv
src/cbm_window_calc.sv
src/cbm_out_buffer.sv
src/cartridge_bank_mapper_irq_unit.sv
tb/sv/cartridge_bank_mapper_irq_unit_test.sv
